// ===== rtl/utf8v_pkg.sv =====
package utf8v_pkg;

   localparam int unsigned CpWidth = 21;

   typedef logic [3:0]         err_type;
   typedef logic [CpWidth-1:0] cp_type;

   localparam err_type ERR_NONE      = 4'd0;
   localparam err_type ERR_NUL       = 4'd1;
   localparam err_type ERR_CONTROL   = 4'd2;
   localparam err_type ERR_LEAD      = 4'd3;
   localparam err_type ERR_CONT      = 4'd4;
   localparam err_type ERR_TRUNC     = 4'd5;
   localparam err_type ERR_OVERLONG  = 4'd6;
   localparam err_type ERR_SURROGATE = 4'd7;
   localparam err_type ERR_TOO_LARGE = 4'd8;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_HIGH  = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD2_HI   = 8'hDF;
   localparam logic [7:0] LEAD3_LO   = 8'hE0;
   localparam logic [7:0] LEAD3_HI   = 8'hEF;
   localparam logic [7:0] LEAD4_LO   = 8'hF0;
   localparam logic [7:0] LEAD4_HI   = 8'hF4;

   localparam cp_type CP_MIN3      = 21'h000800;
   localparam cp_type CP_MIN4      = 21'h010000;
   localparam cp_type CP_SURR_LO   = 21'h00D800;
   localparam cp_type CP_SURR_HI   = 21'h00DFFF;
   localparam cp_type CP_MAX       = 21'h10FFFF;

   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_2    = 3'd2;
   localparam logic [2:0] SEQ_3    = 3'd3;
   localparam logic [2:0] SEQ_4    = 3'd4;

endpackage

// ===== rtl/utf8_text_validator.sv =====
// Strict UTF-8 checker for a byte stream, one byte per item, with the last
// byte of each text marked by req_end_of_text. Every byte gives one result
// carrying the first error of the text so far; the result of the marked byte
// closes the text (rsp_verdict_final) and reports rsp_text_valid when no error
// was found, after which all checker state returns to reset. Throughput is one
// byte per clock while rsp_ready is high. rsp_valid rises once the byte has
// passed through the input register and then the result register, which sit
// around the single decode stage that carries the sequence state from byte to
// byte.
module utf8_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_error_kind,
   output logic       rsp_text_valid,
   output logic       rsp_verdict_final
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // sequence state
   logic [1:0]         exp_ff, exp_in;
   logic [2:0]         len_ff, len_in;
   utf8v_pkg::cp_type  cp_ff, cp_in;
   utf8v_pkg::err_type err_ff, err_in;

   // result register
   logic               out_valid_ff;
   utf8v_pkg::err_type out_err_ff;
   logic               out_ok_ff;
   logic               out_last_ff;

   utf8v_pkg::err_type step_err;
   utf8v_pkg::cp_type  cp_cat;
   logic               out_free;
   logic               advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign cp_cat = {cp_ff[utf8v_pkg::CpWidth-7:0], in_byte_ff[5:0]};

   always_comb begin
      exp_in   = exp_ff;
      len_in   = len_ff;
      cp_in    = cp_ff;
      step_err = utf8v_pkg::ERR_NONE;
      err_in   = err_ff;
      if (err_ff == utf8v_pkg::ERR_NONE) begin
         if (exp_ff == 2'd0) begin
            if (in_byte_ff == utf8v_pkg::BYTE_NUL) begin
               step_err = utf8v_pkg::ERR_NUL;
            end else if (in_byte_ff < utf8v_pkg::BYTE_SPACE) begin
               if (!(in_byte_ff inside {utf8v_pkg::BYTE_TAB, utf8v_pkg::BYTE_LF,
                                        utf8v_pkg::BYTE_CR})) begin
                  step_err = utf8v_pkg::ERR_CONTROL;
               end
            end else if (in_byte_ff < utf8v_pkg::BYTE_HIGH) begin
               step_err = utf8v_pkg::ERR_NONE;
            end else if (in_byte_ff inside {[utf8v_pkg::LEAD2_LO:utf8v_pkg::LEAD2_HI]}) begin
               len_in = utf8v_pkg::SEQ_2;
               exp_in = 2'd1;
               cp_in  = {16'd0, in_byte_ff[4:0]};
            end else if (in_byte_ff inside {[utf8v_pkg::LEAD3_LO:utf8v_pkg::LEAD3_HI]}) begin
               len_in = utf8v_pkg::SEQ_3;
               exp_in = 2'd2;
               cp_in  = {17'd0, in_byte_ff[3:0]};
            end else if (in_byte_ff inside {[utf8v_pkg::LEAD4_LO:utf8v_pkg::LEAD4_HI]}) begin
               len_in = utf8v_pkg::SEQ_4;
               exp_in = 2'd3;
               cp_in  = {18'd0, in_byte_ff[2:0]};
            end else begin
               step_err = utf8v_pkg::ERR_LEAD;
            end
         end else begin
            if (in_byte_ff[7:6] != 2'b10) begin
               step_err = utf8v_pkg::ERR_CONT;
            end else begin
               cp_in  = cp_cat;
               exp_in = exp_ff - 2'd1;
               if (exp_in == 2'd0) begin
                  if ((len_ff == utf8v_pkg::SEQ_3 && cp_cat < utf8v_pkg::CP_MIN3) ||
                      (len_ff == utf8v_pkg::SEQ_4 && cp_cat < utf8v_pkg::CP_MIN4)) begin
                     step_err = utf8v_pkg::ERR_OVERLONG;
                  end else if (cp_cat >= utf8v_pkg::CP_SURR_LO &&
                               cp_cat <= utf8v_pkg::CP_SURR_HI) begin
                     step_err = utf8v_pkg::ERR_SURROGATE;
                  end else if (cp_cat > utf8v_pkg::CP_MAX) begin
                     step_err = utf8v_pkg::ERR_TOO_LARGE;
                  end else begin
                     len_in = utf8v_pkg::SEQ_NONE;
                     cp_in  = '0;
                  end
               end
            end
         end
         if (step_err == utf8v_pkg::ERR_NONE && in_last_ff && exp_in != 2'd0) begin
            step_err = utf8v_pkg::ERR_TRUNC;
         end
         err_in = step_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= 2'd0;
         len_ff <= utf8v_pkg::SEQ_NONE;
         cp_ff  <= '0;
         err_ff <= utf8v_pkg::ERR_NONE;
      end else if (advance) begin
         if (in_last_ff) begin
            exp_ff <= 2'd0;
            len_ff <= utf8v_pkg::SEQ_NONE;
            cp_ff  <= '0;
            err_ff <= utf8v_pkg::ERR_NONE;
         end else begin
            exp_ff <= exp_in;
            len_ff <= len_in;
            cp_ff  <= cp_in;
            err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_err_ff  <= err_in;
         out_ok_ff   <= in_last_ff && (err_in == utf8v_pkg::ERR_NONE);
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_error_kind    = out_err_ff;
   assign rsp_text_valid    = out_ok_ff;
   assign rsp_verdict_final = out_last_ff;

`ifndef SYNTHESIS
   a_valid_means_clean_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_valid) |->
         (rsp_verdict_final && rsp_error_kind == utf8v_pkg::ERR_NONE))
      else $error("text_valid without a clean final byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=>
         (err_ff == utf8v_pkg::ERR_NONE && exp_ff == 2'd0 && len_ff == utf8v_pkg::SEQ_NONE))
      else $error("state not cleared after last byte");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != utf8v_pkg::ERR_NONE && !(advance && in_last_ff)) |=>
         (err_ff == $past(err_ff)))
      else $error("sticky error changed inside a text");

   a_open_seq_len: assert property (@(posedge clock) disable iff (reset)
      (err_ff == utf8v_pkg::ERR_NONE && exp_ff != 2'd0) |->
         (len_ff >= utf8v_pkg::SEQ_2 && {1'b0, exp_ff} < len_ff))
      else $error("open sequence with inconsistent length");
`endif

endmodule
